// ===== design/cfta_pkg.sv =====
// shared types and constants for the coarse/fine tip approach sequencer
package cfta_pkg;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [15:0] MOTOR_STEP_LIMIT = 16'd500;
    localparam logic [15:0] POS_MAX          = 16'hffff;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] REG_TARGET_SIGNAL = 2'd0;
    localparam logic [1:0] REG_COARSE_STEP   = 2'd1;
    localparam logic [1:0] REG_FINE_STEP     = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_COARSE = 2'd1,
        PH_FINE   = 2'd2
    } cfta_phase_t;

    typedef struct packed {
        logic [15:0] target_signal;
        logic [15:0] coarse_step;
        logic [15:0] fine_step;
    } cfta_cfg_t;

    typedef struct packed {
        logic        command;
        logic [15:0] sample_value;
    } cfta_in_t;

    typedef struct packed {
        logic [15:0] piezo_position;
        logic        measure_request;
        logic        motor_on;
        logic        motor_step_down;
        logic        log_valid;
        logic [15:0] log_height;
        logic [15:0] log_signal;
        logic        done_res;
        logic        reached;
        logic [15:0] peak_signal;
    } cfta_out_t;

endpackage

// ===== design/coarse_fine_tip_approach_sequencer_core.sv =====
// top level: input register, sequencer logic, result register, config port
// an accepted item goes through the input register, then the result register
// throughput: one item per cycle while m_ready is high; each item needs one
//   compare and one add against the phase, position and step-count registers
// an input register and a result register decouple the two channels
// reset: aresetn synchronous active low; phase idle, position and step count
//   zero, motor off, config registers at their defaults
module coarse_fine_tip_approach_sequencer_core import cfta_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cfta_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cfta_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfta_cfg_t cfg;
    logic      in_valid_reg;
    cfta_in_t  in_item_reg;
    logic      out_valid_reg;
    cfta_out_t out_item_reg;
    cfta_out_t result;
    logic      advance;

    cfta_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfta_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // item moves into the result register when that slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with free slot");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item lost");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not filled");
`endif

endmodule

// ===== design/cfta_cfg.sv =====
// apb configuration registers
module cfta_cfg import cfta_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfta_cfg_t          cfg
);

    cfta_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_signal <= 16'd32768;
            cfg_reg.coarse_step   <= 16'd1024;
            cfg_reg.fine_step     <= 16'd64;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET_SIGNAL: cfg_reg.target_signal <= pwdata[15:0];
                REG_COARSE_STEP:   cfg_reg.coarse_step   <= pwdata[15:0];
                REG_FINE_STEP:     cfg_reg.fine_step     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TARGET_SIGNAL: prdata = {16'd0, cfg_reg.target_signal};
            REG_COARSE_STEP:   prdata = {16'd0, cfg_reg.coarse_step};
            REG_FINE_STEP:     prdata = {16'd0, cfg_reg.fine_step};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== design/cfta_seq.sv =====
// approach state registers and per-item decision logic
module cfta_seq import cfta_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfta_cfg_t cfg,
    input  logic      fire,
    input  cfta_in_t  item,
    output cfta_out_t result
);

    cfta_phase_t phase_reg, phase_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] steps_reg, steps_next;
    logic        motor_reg, motor_next;

    logic        busy;
    logic        is_start;
    logic        hit;
    logic [15:0] c_step, f_step;
    logic [16:0] c_sum, f_sum;
    logic        c_ovf, f_ovf;
    logic [15:0] steps_inc;
    logic        at_limit;

    assign busy      = (phase_reg == PH_COARSE) || (phase_reg == PH_FINE);
    assign is_start  = (item.command == CMD_START);
    assign hit       = (item.sample_value >= cfg.target_signal);
    // zero step acts as one so a sweep always ends
    assign c_step    = (cfg.coarse_step == 16'd0) ? 16'd1 : cfg.coarse_step;
    assign f_step    = (cfg.fine_step == 16'd0) ? 16'd1 : cfg.fine_step;
    assign c_sum     = {1'b0, disp_reg} + {1'b0, c_step};
    assign f_sum     = {1'b0, disp_reg} + {1'b0, f_step};
    assign c_ovf     = c_sum[16];
    assign f_ovf     = f_sum[16];
    assign steps_inc = steps_reg + 16'd1;
    assign at_limit  = (steps_inc >= MOTOR_STEP_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            disp_reg  <= '0;
            steps_reg <= '0;
            motor_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            disp_reg  <= disp_next;
            steps_reg <= steps_next;
            motor_reg <= motor_next;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        disp_next  = disp_reg;
        steps_next = steps_reg;
        motor_next = motor_reg;
        if (fire) begin
            if (is_start) begin
                if (!busy) begin
                    phase_next = PH_COARSE;
                    disp_next  = '0;
                    steps_next = '0;
                    motor_next = 1'b1;
                end
            end else if (busy) begin
                unique case (phase_reg)
                    PH_COARSE: begin
                        if (hit) begin
                            motor_next = 1'b0;
                            phase_next = PH_FINE;
                            disp_next  = '0;
                        end else if (!c_ovf) begin
                            disp_next = c_sum[15:0];
                        end else begin
                            steps_next = steps_inc;
                            if (at_limit) begin
                                motor_next = 1'b0;
                                phase_next = PH_IDLE;
                            end else begin
                                disp_next = '0;
                            end
                        end
                    end
                    PH_FINE: begin
                        if (hit || f_ovf) begin
                            phase_next = PH_IDLE;
                        end else begin
                            disp_next = f_sum[15:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result of the current item
    always_comb begin
        result                = '0;
        result.piezo_position = disp_reg;
        result.motor_on       = motor_next;
        if (is_start) begin
            if (!busy) begin
                result.piezo_position  = '0;
                result.measure_request = 1'b1;
            end
        end else if (busy) begin
            result.log_valid  = 1'b1;
            result.log_height = disp_reg;
            result.log_signal = item.sample_value;
            unique case (phase_reg)
                PH_COARSE: begin
                    if (hit) begin
                        result.piezo_position  = '0;
                        result.measure_request = 1'b1;
                        result.peak_signal     = item.sample_value;
                    end else if (!c_ovf) begin
                        result.piezo_position  = c_sum[15:0];
                        result.measure_request = 1'b1;
                    end else begin
                        result.motor_step_down = 1'b1;
                        if (at_limit) begin
                            result.done_res    = 1'b1;
                            result.peak_signal = item.sample_value;
                        end else begin
                            result.piezo_position  = '0;
                            result.measure_request = 1'b1;
                        end
                    end
                end
                PH_FINE: begin
                    if (hit || f_ovf) begin
                        result.done_res    = 1'b1;
                        result.reached     = 1'b1;
                        result.peak_signal = item.sample_value;
                    end else begin
                        result.piezo_position  = f_sum[15:0];
                        result.measure_request = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.done_res |=> phase_reg == PH_IDLE)
        else $error("phase not idle after approach end");

    a_reached_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        result.reached |-> result.done_res && !result.measure_request)
        else $error("reached without done");

    a_motor_off_in_fine: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FINE |-> !motor_reg)
        else $error("motor on during fine sweep");

    a_step_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.motor_step_down |=> steps_reg == $past(steps_reg) + 16'd1)
        else $error("motor step not counted");
`endif

endmodule
